// ===== rtl/rgb_xyz_color_matrix_core_defines.svh =====
// Assertion helpers for the color matrix core.
`ifndef RGB_XYZ_COLOR_MATRIX_CORE_DEFINES_SVH
`define RGB_XYZ_COLOR_MATRIX_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RXCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RXCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rxcm_pkg.sv =====
package rxcm_pkg;

    localparam int COMP_W = 20;
    localparam int COEF_W = 19;
    localparam int FRAC_W = 16;
    localparam int PROD_W = COMP_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int NCOMP  = 3;
    localparam int NCOEF  = NCOMP * NCOMP;

    localparam logic GAMUT_SRGB   = 1'b0;
    localparam logic GAMUT_P3     = 1'b1;
    localparam logic MODE_XYZ2RGB = 1'b0;
    localparam logic MODE_RGB2XYZ = 1'b1;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam comp_t COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
    localparam comp_t COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

    typedef coef_t [NCOEF-1:0] coef_set_t;

    typedef struct packed {
        logic  mode;
        comp_t first_in;
        comp_t second_in;
        comp_t third_in;
    } pix_t;

    typedef struct packed {
        comp_t first_out;
        comp_t second_out;
        comp_t third_out;
        logic  clipped;
    } res_t;

    typedef struct packed {
        comp_t [NCOMP-1:0] comp;
        coef_set_t         coef;
    } stg1_t;

    typedef struct packed {
        prod_t [NCOEF-1:0] prod;
    } stg2_t;

    typedef struct packed {
        sum_t [NCOMP-1:0] sum;
    } stg3_t;

    // Q2.16 coefficients, row-major: entry row*3+col
    function automatic coef_set_t coef_lookup(input logic gamut, input logic mode);
        coef_set_t c;
        c = '0;
        if (gamut == GAMUT_SRGB && mode == MODE_XYZ2RGB) begin
            c[0] = 19'sd212400;  c[1] = -19'sd100754; c[2] = -19'sd32677;
            c[3] = -19'sd63520;  c[4] = 19'sd122943;  c[5] = 19'sd2723;
            c[6] = 19'sd3646;    c[7] = -19'sd13368;  c[8] = 19'sd69270;
        end else if (gamut == GAMUT_SRGB && mode == MODE_RGB2XYZ) begin
            c[0] = 19'sd27026;   c[1] = 19'sd23435;   c[2] = 19'sd11828;
            c[3] = 19'sd13936;   c[4] = 19'sd46869;   c[5] = 19'sd4731;
            c[6] = 19'sd1267;    c[7] = 19'sd7812;    c[8] = 19'sd62294;
        end else if (gamut == GAMUT_P3 && mode == MODE_XYZ2RGB) begin
            c[0] = 19'sd163414;  c[1] = -19'sd61039;  c[2] = -19'sd26392;
            c[3] = -19'sd54361;  c[4] = 19'sd115518;  c[5] = 19'sd1548;
            c[6] = 19'sd2349;    c[7] = -19'sd4992;   c[8] = 19'sd62710;
        end else begin
            c[0] = 19'sd31888;   c[1] = 19'sd17411;   c[2] = 19'sd12990;
            c[3] = 19'sd15006;   c[4] = 19'sd45334;   c[5] = 19'sd5196;
            c[6] = 19'sd0;       c[7] = 19'sd2957;    c[8] = 19'sd68416;
        end
        return c;
    endfunction

endpackage

// ===== rtl/rxcm_coef.sv =====
module rxcm_coef (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rxcm_pkg::pix_t in_item,
    input  logic           gamut,
    output logic           out_valid,
    input  logic           out_ready,
    output rxcm_pkg::stg1_t out_item
);
    import rxcm_pkg::*;

    logic  valid_reg;
    stg1_t item_reg;
    stg1_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item_next.comp[0] = in_item.first_in;
        item_next.comp[1] = in_item.second_in;
        item_next.comp[2] = in_item.third_in;
        item_next.coef    = coef_lookup(gamut, in_item.mode);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

// ===== rtl/rxcm_mul.sv =====
module rxcm_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rxcm_pkg::stg1_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output rxcm_pkg::stg2_t out_item
);
    import rxcm_pkg::*;

    logic  valid_reg;
    stg2_t item_reg;
    stg2_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // nine independent 19x20 signed products
    always_comb
    begin
        for (int r = 0; r < NCOMP; r++) begin
            for (int c = 0; c < NCOMP; c++) begin
                item_next.prod[r*NCOMP+c] = $signed(in_item.coef[r*NCOMP+c])
                                          * $signed(in_item.comp[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

// ===== rtl/rxcm_acc.sv =====
module rxcm_acc (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rxcm_pkg::stg2_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output rxcm_pkg::stg3_t out_item
);
    import rxcm_pkg::*;

    localparam sum_t ROUND_BIAS = SUM_W'(2 ** (FRAC_W - 1));

    logic  valid_reg;
    stg3_t item_reg;
    stg3_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // row sum with the half-LSB bias folded in
    always_comb
    begin
        for (int r = 0; r < NCOMP; r++) begin
            item_next.sum[r] = SUM_W'(in_item.prod[r*NCOMP])
                             + SUM_W'(in_item.prod[r*NCOMP+1])
                             + SUM_W'(in_item.prod[r*NCOMP+2])
                             + ROUND_BIAS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

// ===== rtl/rxcm_sat.sv =====
module rxcm_sat (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rxcm_pkg::stg3_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output rxcm_pkg::res_t  out_item
);
    import rxcm_pkg::*;

    localparam int Q_W = SUM_W - FRAC_W;

    logic             valid_reg;
    res_t             item_reg;
    res_t             item_next;
    comp_t [NCOMP-1:0] val;
    logic [NCOMP-1:0]  ovf;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // drop fraction (floor), then clamp to Q3.16
    always_comb
    begin
        logic [Q_W-1:0] q;
        for (int r = 0; r < NCOMP; r++) begin
            q = in_item.sum[r][SUM_W-1:FRAC_W];
            ovf[r] = !((&q[Q_W-1:COMP_W-1]) || !(|q[Q_W-1:COMP_W-1]));
            if (ovf[r])
                val[r] = q[Q_W-1] ? COMP_MIN : COMP_MAX;
            else
                val[r] = q[COMP_W-1:0];
        end
        item_next.first_out  = val[0];
        item_next.second_out = val[1];
        item_next.third_out  = val[2];
        item_next.clipped    = |ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

// ===== rtl/rgb_xyz_color_matrix_core.sv =====
// channel  | handshake                | payload
// pix      | pix_valid / pix_stall    | rxcm_pkg::pix_t (mode, three Q3.16 components)
// res      | res_valid / res_stall    | rxcm_pkg::res_t (three Q3.16 results, clipped)
// cfg      | cfg_valid / cfg_ready    | cfg_gamut (0 sRGB, 1 Display P3)
//
// One item per cycle while res_stall is low; each item passes the four registered stages from pix to res.
// Stages: coefficient select, 3x3 multiply, row sum + round, saturate.
// rst_n (async, active low) empties the pipeline and sets the gamut to sRGB.
// Each stage moves on when it is empty or the next one moves; a res_stall
// backs up stage by stage, so bubbles are squeezed out before pix_stall rises.
module rgb_xyz_color_matrix_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pix_valid,
    output logic           pix_stall,
    input  rxcm_pkg::pix_t pix,
    output logic           res_valid,
    input  logic           res_stall,
    output rxcm_pkg::res_t res,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_gamut
);
    import rxcm_pkg::*;
    `include "rgb_xyz_color_matrix_core_defines.svh"

    logic  gamut_reg;
    logic  rdy1, rdy2, rdy3, rdy4;
    logic  v1, v2, v3;
    stg1_t s1;
    stg2_t s2;
    stg3_t s3;

    assign cfg_ready = 1'b1;
    assign pix_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gamut_reg <= GAMUT_SRGB;
        else if (cfg_valid && cfg_ready)
            gamut_reg <= cfg_gamut;
    end

    rxcm_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_valid),
        .in_ready  (rdy1),
        .in_item   (pix),
        .gamut     (gamut_reg),
        .out_valid (v1),
        .out_ready (rdy2),
        .out_item  (s1)
    );

    rxcm_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (rdy2),
        .in_item   (s1),
        .out_valid (v2),
        .out_ready (rdy3),
        .out_item  (s2)
    );

    rxcm_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_ready  (rdy3),
        .in_item   (s2),
        .out_valid (v3),
        .out_ready (rdy4),
        .out_item  (s3)
    );

    rxcm_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3),
        .in_ready  (rdy4),
        .in_item   (s3),
        .out_valid (res_valid),
        .out_ready (!res_stall),
        .out_item  (res)
    );

    // input can only back up when the full pipeline is held at the output
    `RXCM_ASSERT_NOW(a_stall_only_when_full, pix_stall, res_valid && res_stall && v1 && v2 && v3, "pix_stall with room in the pipeline")
    // an accepted item lands in the first stage
    `RXCM_ASSERT_NEXT(a_accept_fills_s1, pix_valid && !pix_stall, v1, "accepted item lost at first stage")
    // clip flag implies some output sits on a rail
    `RXCM_ASSERT_NOW(a_clip_on_rail, res_valid && res.clipped, res.first_out == COMP_MAX || res.first_out == COMP_MIN || res.second_out == COMP_MAX || res.second_out == COMP_MIN || res.third_out == COMP_MAX || res.third_out == COMP_MIN, "clipped set with no saturated output")

endmodule

// ===== dv/testbench.sv =====
import rxcm_pkg::*;

class color_board;
    int   coef_tab [36];
    logic gamut;
    res_t expected_colors [$];
    int   errors;
    int   n_checked;
    int   n_clipped;
    int   n_p3;
    int   n_rgb2xyz;

    function new();
        gamut     = GAMUT_SRGB;
        errors    = 0;
        n_checked = 0;
        n_clipped = 0;
        n_p3      = 0;
        n_rgb2xyz = 0;
        // [gamut][mode][row][col], scaled by 2^16
        coef_tab = '{
            212400, -100754, -32677, -63520, 122943, 2723, 3646, -13368, 69270,
            27026, 23435, 11828, 13936, 46869, 4731, 1267, 7812, 62294,
            163414, -61039, -26392, -54361, 115518, 1548, 2349, -4992, 62710,
            31888, 17411, 12990, 15006, 45334, 5196, 0, 2957, 68416};
    endfunction

    function void set_gamut(logic g);
        gamut = g;
    endfunction

    function int pending();
        return expected_colors.size();
    endfunction

    function res_t convert_pixel(pix_t p);
        longint v [3];
        longint acc;
        longint q;
        comp_t  o [3];
        logic   clip;
        int     base;
        int     row;
        int     col;
        res_t   r;
        v[0] = longint'($signed(p.first_in));
        v[1] = longint'($signed(p.second_in));
        v[2] = longint'($signed(p.third_in));
        base = ((gamut == GAMUT_P3) ? 18 : 0) + ((p.mode == MODE_RGB2XYZ) ? 9 : 0);
        clip = 1'b0;
        for (row = 0; row < 3; row++) begin
            acc = 0;
            for (col = 0; col < 3; col++)
                acc += longint'(coef_tab[base + row * 3 + col]) * v[col];
            // round half up, then floor back to 16 fraction bits
            q = (acc + 64'sd32768) >>> 16;
            if (q > 524287) begin
                q    = 524287;
                clip = 1'b1;
            end else if (q < -524288) begin
                q    = -524288;
                clip = 1'b1;
            end
            o[row] = comp_t'(q);
        end
        r.first_out  = o[0];
        r.second_out = o[1];
        r.third_out  = o[2];
        r.clipped    = clip;
        return r;
    endfunction

    function void note_pixel(pix_t p);
        if (gamut == GAMUT_P3)
            n_p3++;
        if (p.mode == MODE_RGB2XYZ)
            n_rgb2xyz++;
        expected_colors.push_back(convert_pixel(p));
    endfunction

    function void check_color(res_t got);
        res_t want;
        logic bad;
        if (expected_colors.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: result with nothing outstanding: %0d %0d %0d clip=%0b",
                         got.first_out, got.second_out, got.third_out, got.clipped);
            return;
        end
        want = expected_colors.pop_front();
        n_checked++;
        if (want.clipped)
            n_clipped++;
        bad = (got.first_out !== want.first_out) || (got.second_out !== want.second_out)
            || (got.third_out !== want.third_out) || (got.clipped !== want.clipped);
        if (bad) begin
            errors++;
            if (errors <= 10)
                $display("ERROR: result %0d exp %0d %0d %0d clip=%0b got %0d %0d %0d clip=%0b",
                         n_checked, want.first_out, want.second_out, want.third_out,
                         want.clipped, got.first_out, got.second_out, got.third_out,
                         got.clipped);
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    STALL_LIMIT = 4000;
    localparam int    DRAIN_WAIT  = 12;
    localparam comp_t UNITY       = 20'sd65536;

    logic clk = 1'b0;
    logic rst_n;
    logic pix_valid;
    logic pix_stall;
    pix_t pix;
    logic res_valid;
    logic res_stall;
    res_t res;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_gamut;

    color_board sb;
    bit         quiet;
    int         hold_cycles;
    int         idle_count;
    int         n_cfg;

    always #1 clk = ~clk;

    rgb_xyz_color_matrix_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_gamut (cfg_gamut)
    );

    // monitor and watchdog
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if (pix_valid && !pix_stall)
                sb.note_pixel(pix);
            if (res_valid && !res_stall)
                sb.check_color(res);
            if (cfg_valid && cfg_ready)
                sb.set_gamut(cfg_gamut);
            if ((pix_valid && !pix_stall) || (res_valid && !res_stall)
                || (cfg_valid && cfg_ready))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= STALL_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
                $display("rgb_xyz_color_matrix_core test failed");
                $finish;
            end
        end
    end

    // result side: a random hold-off before each item, or a long hold on request
    initial begin
        int n;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
            end else begin
                n = quiet ? 0 : $urandom_range(0, 16);
            end
            @(negedge clk);
            if (n > 0) begin
                res_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (res_valid !== 1'b1);
        end
    end

    function automatic pix_t mk_pix(logic m, comp_t a, comp_t b, comp_t c);
        pix_t p;
        p.mode      = m;
        p.first_in  = a;
        p.second_in = b;
        p.third_in  = c;
        return p;
    endfunction

    function automatic comp_t rand_comp();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return comp_t'($urandom);
        if (pick < 8)
            return comp_t'(int'($urandom_range(0, 196608)) - 98304);
        case ($urandom_range(0, 4))
            0: return COMP_MAX;
            1: return COMP_MIN;
            2: return UNITY;
            3: return -UNITY;
            default: return '0;
        endcase
    endfunction

    function automatic pix_t random_pixel();
        logic m;
        m = ($urandom_range(0, 1) == 1) ? MODE_RGB2XYZ : MODE_XYZ2RGB;
        return mk_pix(m, rand_comp(), rand_comp(), rand_comp());
    endfunction

    task automatic send_pix(input pix_t p);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do @(posedge clk); while (pix_stall !== 1'b0);
    endtask

    task automatic end_burst();
        @(negedge clk);
        pix_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_gamut(input logic g);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_gamut <= g;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // zeros, full-scale, mixed-sign saturation and unity white, both directions
    task automatic run_directed();
        logic m;
        int   k;
        quiet = 1'b0;
        for (k = 0; k < 2; k++) begin
            m = (k == 0) ? MODE_XYZ2RGB : MODE_RGB2XYZ;
            send_pix(mk_pix(m, '0, '0, '0));
            send_pix(mk_pix(m, COMP_MAX, COMP_MAX, COMP_MAX));
            send_pix(mk_pix(m, COMP_MIN, COMP_MIN, COMP_MIN));
            send_pix(mk_pix(m, COMP_MAX, COMP_MIN, COMP_MIN));
            send_pix(mk_pix(m, COMP_MIN, COMP_MAX, COMP_MAX));
            send_pix(mk_pix(m, UNITY, UNITY, UNITY));
        end
        end_burst();
    endtask

    task automatic run_random(input int count, input bit squeeze);
        int k;
        for (k = 0; k < count; k++) begin
            if (k % 64 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (squeeze && k == 0)
                hold_cycles = 240;
            // keep offering back to back while the output is held
            if (squeeze && k < 80)
                quiet = 1'b1;
            send_pix(random_pixel());
        end
        end_burst();
        quiet = 1'b0;
    endtask

    initial begin
        sb          = new();
        quiet       = 1'b0;
        hold_cycles = 0;
        idle_count  = 0;
        n_cfg       = 0;
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix       <= '0;
        cfg_valid <= 1'b0;
        cfg_gamut <= GAMUT_SRGB;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        drain();
        write_gamut(GAMUT_P3);
        run_directed();
        drain();

        run_random(320, 1'b0);
        drain();
        write_gamut(GAMUT_SRGB);
        run_random(320, 1'b1);
        drain();
        write_gamut(GAMUT_P3);
        run_random(320, 1'b0);
        drain();
        write_gamut(GAMUT_SRGB);
        run_random(340, 1'b0);

        drain();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d colors checked: %0d under Display P3, %0d RGB to XYZ, %0d saturated",
                 sb.n_checked, sb.n_p3, sb.n_rgb2xyz, sb.n_clipped);
        $display("%0d gamut writes, one long output hold-off, %0d errors", n_cfg, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("rgb_xyz_color_matrix_core test passed");
        else
            $display("rgb_xyz_color_matrix_core test failed");
        $finish;
    end
endmodule
